// File: hw/rtl/twq_pkg.sv
// ----------------------------------------------------------------------------
// twq_pkg
// Shared constants, codes and types of the timed wait queue.
// ----------------------------------------------------------------------------
package twq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int AW          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW          = $clog2(QUEUE_DEPTH + 1);

  localparam int MODE_W   = 3;
  localparam int ID_W     = 16;
  localparam int LIMIT_W  = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [MODE_W-1:0] MODE_INSERT        = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE        = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FIND          = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TAKE_FIRST    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TAKE_UNTIMED  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_TAKE_TIMED    = 3'd5;
  localparam logic [MODE_W-1:0] MODE_TICK          = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUP      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic               timed;
    logic [LIMIT_W-1:0] limit;
    logic [LIMIT_W-1:0] elapsed;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_REL_RD,
    S_REL_OUT,
    S_FINAL
  } state_t;

  typedef struct packed {
    logic start;
    logic walk;
    logic rel_read;
    logic rel_emit;
    logic final_emit;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic is_tick;
    logic rel_any;
    logic rel_last;
    logic out_free;
  } sts_t;

endpackage

// File: hw/rtl/twq_if.sv
// ----------------------------------------------------------------------------
// twq_if
// Valid/ready channel interfaces for the queue commands and their results.
// ----------------------------------------------------------------------------
interface twq_in_if;
  import twq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [MODE_W-1:0]     mode;
  logic [ID_W-1:0]       entry_id;
  logic                  timed;
  logic [LIMIT_W-1:0]    wait_limit;

  modport source (output valid, output mode, output entry_id, output timed,
                  output wait_limit, input ready);
  modport sink (input valid, input mode, input entry_id, input timed,
                input wait_limit, output ready);
endinterface

interface twq_out_if;
  import twq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [ID_W-1:0]       result_id;
  logic [COUNT_W-1:0]    released_count;
  logic [COUNT_W-1:0]    occupancy;
  logic                  last;

  modport source (output valid, output status, output result_id,
                  output released_count, output occupancy, output last,
                  input ready);
  modport sink (input valid, input status, input result_id,
                input released_count, input occupancy, input last,
                output ready);
endinterface

// File: hw/rtl/timed_wait_queue_top.sv
// ----------------------------------------------------------------------------
// timed_wait_queue_top
// One command at a time; a walk reads the queued entries in order from the queue RAM.
// The walk reads one entry per cycle; a tick then emits each released id before
// the closing result, and these emissions can stall on the result side.
// A new command is taken once the previous closing result is registered.
// Synchronous reset empties the queue by clearing the entry count, not the queue RAM.
// ----------------------------------------------------------------------------
module timed_wait_queue_top (
  input logic       clk,
  input logic       rst_n,
  twq_in_if.sink    in_chan,
  twq_out_if.source out_chan
);
  import twq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  twq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  twq_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_mode            (in_chan.mode),
    .in_entry_id        (in_chan.entry_id),
    .in_timed           (in_chan.timed),
    .in_wait_limit      (in_chan.wait_limit),
    .out_ready          (out_chan.ready),
    .out_valid          (out_chan.valid),
    .out_status         (out_chan.status),
    .out_result_id      (out_chan.result_id),
    .out_released_count (out_chan.released_count),
    .out_occupancy      (out_chan.occupancy),
    .out_last           (out_chan.last)
  );

endmodule

// File: hw/rtl/twq_ram.sv
// ----------------------------------------------------------------------------
// twq_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module twq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/twq_ctrl.sv
// ----------------------------------------------------------------------------
// twq_ctrl
// Sequencer of the timed wait queue: accept, walk, release emission, close.
// ----------------------------------------------------------------------------
module twq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  twq_pkg::sts_t sts,
  output twq_pkg::cmd_t cmd
);
  import twq_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.walk_done) begin
          state_nxt = (sts.is_tick && sts.rel_any) ? S_REL_RD : S_FINAL;
        end
      end
      S_REL_RD: begin
        state_nxt = S_REL_OUT;
      end
      S_REL_OUT: begin
        if (sts.out_free) begin
          state_nxt = sts.rel_last ? S_FINAL : S_REL_RD;
        end
      end
      S_FINAL: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
      end
      S_REL_RD: begin
        cmd.rel_read = 1'b1;
      end
      S_REL_OUT: begin
        cmd.rel_emit = sts.out_free;
      end
      S_FINAL: begin
        cmd.final_emit = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: hw/rtl/twq_datapath.sv
// ----------------------------------------------------------------------------
// twq_datapath
// Queue storage, compacting walk, release buffer and result register.
// ----------------------------------------------------------------------------
module twq_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  twq_pkg::cmd_t                   cmd,
  output twq_pkg::sts_t                   sts,
  input  logic [twq_pkg::MODE_W-1:0]      in_mode,
  input  logic [twq_pkg::ID_W-1:0]        in_entry_id,
  input  logic                            in_timed,
  input  logic [twq_pkg::LIMIT_W-1:0]     in_wait_limit,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [twq_pkg::STATUS_W-1:0]    out_status,
  output logic [twq_pkg::ID_W-1:0]        out_result_id,
  output logic [twq_pkg::COUNT_W-1:0]     out_released_count,
  output logic [twq_pkg::COUNT_W-1:0]     out_occupancy,
  output logic                            out_last
);
  import twq_pkg::*;

  logic [MODE_W-1:0]   mode_r;
  logic [ID_W-1:0]     key_id_r;
  logic                key_timed_r;
  logic [LIMIT_W-1:0]  key_limit_r;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]       wr_idx_r, wr_idx_nxt;
  logic [CW-1:0]       rel_cnt_r, rel_cnt_nxt;
  logic [CW-1:0]       emit_idx_r, emit_idx_nxt;
  logic                pend_r, pend_nxt;
  logic                hit_r, hit_nxt;
  logic [ID_W-1:0]     got_id_r, got_id_nxt;
  logic [STATUS_W-1:0] fin_status_r, fin_status_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [ID_W-1:0]     out_id_r, out_id_nxt;
  logic [COUNT_W-1:0]  out_rel_r, out_rel_nxt;
  logic [COUNT_W-1:0]  out_occ_r, out_occ_nxt;
  logic                out_last_r, out_last_nxt;

  logic                q_we, q_re;
  logic [AW-1:0]       q_waddr;
  logic [ENTRY_W-1:0]  q_wdata, q_rdata;
  logic                r_we;
  logic [ID_W-1:0]     r_rdata;

  entry_t              ent, ent_upd, ent_new;
  logic [LIMIT_W-1:0]  elapsed_inc;
  logic                match_id, kind_hit, hit_now, release_now, drop, is_take;
  logic                walk_done, issue, commit, ins_ok, out_free;

  twq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (q_rdata)
  );

  twq_ram #(.WIDTH(ID_W), .DEPTH(QUEUE_DEPTH)) u_release_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (rel_cnt_r[AW-1:0]),
    .wdata (ent.id),
    .re    (cmd.rel_read),
    .raddr (emit_idx_r[AW-1:0]),
    .rdata (r_rdata)
  );

  always_comb begin
    ent         = entry_t'(q_rdata);
    match_id    = (ent.id == key_id_r);
    elapsed_inc = (ent.timed && (ent.elapsed != {LIMIT_W{1'b1}})) ?
                  ent.elapsed + LIMIT_W'(1) : ent.elapsed;
    ent_upd     = ent;
    if (mode_r == MODE_TICK) begin
      ent_upd.elapsed = elapsed_inc;
    end
    release_now = (mode_r == MODE_TICK) && ent.timed && (elapsed_inc >= ent.limit);

    kind_hit = 1'b0;
    is_take  = 1'b0;
    hit_now  = 1'b0;
    case (mode_r)
      MODE_INSERT, MODE_FIND: begin
        hit_now = match_id;
      end
      MODE_REMOVE: begin
        hit_now = match_id;
        is_take = 1'b1;
      end
      MODE_TAKE_FIRST: begin
        kind_hit = 1'b1;
        hit_now  = kind_hit;
        is_take  = 1'b1;
      end
      MODE_TAKE_UNTIMED: begin
        kind_hit = !ent.timed;
        hit_now  = kind_hit;
        is_take  = 1'b1;
      end
      MODE_TAKE_TIMED: begin
        kind_hit = ent.timed;
        hit_now  = kind_hit;
        is_take  = 1'b1;
      end
      default: begin
        hit_now = 1'b0;
      end
    endcase
    hit_now = hit_now && pend_r && !hit_r;
    drop    = pend_r && (release_now || (hit_now && is_take));

    walk_done = (rd_idx_r == count_r) && !pend_r;
    issue     = cmd.walk && (rd_idx_r != count_r);
    commit    = cmd.walk && walk_done;
    ins_ok    = (mode_r == MODE_INSERT) && !hit_r && (wr_idx_r != CW'(QUEUE_DEPTH));
    out_free  = !out_valid_r || out_ready;

    ent_new.id      = key_id_r;
    ent_new.timed   = key_timed_r;
    ent_new.limit   = key_limit_r;
    ent_new.elapsed = '0;

    q_re    = issue;
    q_we    = 1'b0;
    q_waddr = wr_idx_r[AW-1:0];
    q_wdata = ent_upd;
    if (cmd.walk && pend_r && !drop) begin
      q_we = 1'b1;
    end else if (commit && ins_ok) begin
      q_we    = 1'b1;
      q_wdata = ent_new;
    end
    r_we = cmd.walk && pend_r && release_now;
  end

  always_comb begin
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    wr_idx_nxt     = wr_idx_r;
    rel_cnt_nxt    = rel_cnt_r;
    emit_idx_nxt   = emit_idx_r;
    pend_nxt       = pend_r;
    hit_nxt        = hit_r;
    got_id_nxt     = got_id_r;
    fin_status_nxt = fin_status_r;

    if (cmd.start) begin
      rd_idx_nxt     = '0;
      wr_idx_nxt     = '0;
      rel_cnt_nxt    = '0;
      emit_idx_nxt   = '0;
      pend_nxt       = 1'b0;
      hit_nxt        = 1'b0;
      got_id_nxt     = '0;
      fin_status_nxt = ST_OK;
    end

    if (cmd.walk) begin
      pend_nxt = issue;
      if (issue) begin
        rd_idx_nxt = rd_idx_r + CW'(1);
      end
      if (pend_r) begin
        if (!drop) begin
          wr_idx_nxt = wr_idx_r + CW'(1);
        end
        if (release_now) begin
          rel_cnt_nxt = rel_cnt_r + CW'(1);
        end
        if (hit_now) begin
          hit_nxt = 1'b1;
          if (mode_r != MODE_INSERT) begin
            got_id_nxt = ent.id;
          end
        end
      end
    end

    if (commit) begin
      count_nxt = ins_ok ? wr_idx_r + CW'(1) : wr_idx_r;
      case (mode_r)
        MODE_INSERT: begin
          if (hit_r) begin
            fin_status_nxt = ST_DUP;
          end else if (!ins_ok) begin
            fin_status_nxt = ST_FULL;
          end else begin
            fin_status_nxt = ST_OK;
          end
        end
        MODE_REMOVE, MODE_FIND, MODE_TAKE_FIRST, MODE_TAKE_UNTIMED, MODE_TAKE_TIMED: begin
          fin_status_nxt = hit_r ? ST_OK : ST_NOTFOUND;
        end
        default: begin
          fin_status_nxt = ST_OK;
        end
      endcase
    end

    if (cmd.rel_emit) begin
      emit_idx_nxt = emit_idx_r + CW'(1);
    end
  end

  always_comb begin
    out_valid_nxt  = out_ready ? 1'b0 : out_valid_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_rel_nxt    = out_rel_r;
    out_occ_nxt    = out_occ_r;
    out_last_nxt   = out_last_r;
    if (cmd.rel_emit) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_OK;
      out_id_nxt     = r_rdata;
      out_rel_nxt    = '0;
      out_occ_nxt    = COUNT_W'(count_r);
      out_last_nxt   = 1'b0;
    end else if (cmd.final_emit) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = fin_status_r;
      out_id_nxt     = got_id_r;
      out_rel_nxt    = COUNT_W'(rel_cnt_r);
      out_occ_nxt    = COUNT_W'(count_r);
      out_last_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_r      <= in_mode;
      key_id_r    <= in_entry_id;
      key_timed_r <= in_timed;
      key_limit_r <= in_wait_limit;
    end
    rd_idx_r     <= rd_idx_nxt;
    wr_idx_r     <= wr_idx_nxt;
    rel_cnt_r    <= rel_cnt_nxt;
    emit_idx_r   <= emit_idx_nxt;
    hit_r        <= hit_nxt;
    got_id_r     <= got_id_nxt;
    fin_status_r <= fin_status_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_rel_r    <= out_rel_nxt;
    out_occ_r    <= out_occ_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_comb begin
    sts.walk_done = walk_done;
    sts.is_tick   = (mode_r == MODE_TICK);
    sts.rel_any   = (rel_cnt_r != '0);
    sts.rel_last  = ((emit_idx_r + CW'(1)) == rel_cnt_r);
    sts.out_free  = out_free;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_id      = out_id_r;
  assign out_released_count = out_rel_r;
  assign out_occupancy      = out_occ_r;
  assign out_last           = out_last_r;

endmodule

// File: test/timed_wait_queue_top_tb.sv
// ----------------------------------------------------------------------------
// timed_wait_queue_top_tb
// Runs directed and random queue commands through the wait queue, with bursty
// command traffic and a stalling result side. A behavioral copy of the queue
// predicts every result, and each result transfer is checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timed_wait_queue_top_tb;
  import twq_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS  = 104;
  localparam int ID_POOL_SIZE  = 24;
  localparam int SETTLE_CYCLES = 64;
  localparam int MODE_CUT [3][7] = '{'{60, 65, 75, 80, 83, 86, 98},
                                     '{25, 35, 45, 55, 65, 75, 96},
                                     '{10, 25, 30, 40, 50, 65, 98}};
  localparam logic [MODE_W-1:0] MODE_ORDER [7] = '{MODE_INSERT, MODE_REMOVE, MODE_FIND,
                                                  MODE_TAKE_FIRST, MODE_TAKE_UNTIMED,
                                                  MODE_TAKE_TIMED, MODE_TICK};

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [ID_W-1:0]    entry_id;
    logic               timed;
    logic [LIMIT_W-1:0] wait_limit;
  } command_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
    logic [COUNT_W-1:0]  rel;
    logic [COUNT_W-1:0]  occ;
    logic                last;
  } result_t;

  logic clk;
  logic rst_n;

  twq_in_if  in_if ();
  twq_out_if out_if ();

  timed_wait_queue_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  entry_t          queue_slot [QUEUE_DEPTH];
  int              live_count = 0;
  command_t        cmd_backlog [$];
  result_t         pending_results [$];
  command_t        on_wire;
  result_t         got;
  result_t         want;
  logic [ID_W-1:0] id_pool [ID_POOL_SIZE];
  int              fault_count = 0;
  int              gap_left    = 0;
  int              burst_left  = 0;
  int              style_left  = 0;
  int              ready_style = 0;
  logic [7:0]      stall_word  = 8'h01;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic result_t make_result(input logic [STATUS_W-1:0] status,
                                          input logic [ID_W-1:0] id,
                                          input int rel, input logic last);
    result_t r;
    r.status = status;
    r.id     = id;
    r.rel    = COUNT_W'(rel);
    r.occ    = '0;
    r.last   = last;
    return r;
  endfunction

  function automatic int locate_id(input logic [ID_W-1:0] id);
    for (int i = 0; i < live_count; i++)
      if (queue_slot[i].id == id) return i;
    return -1;
  endfunction

  function automatic void drop_slot(input int pos);
    for (int i = pos; i + 1 < live_count; i++) queue_slot[i] = queue_slot[i + 1];
    live_count--;
  endfunction

  function automatic void apply_command(input command_t c);
    result_t step_out [$];
    int      pos;
    int      i;
    int      released;
    pos      = -1;
    released = 0;
    case (c.mode)
      MODE_INSERT: begin
        if (locate_id(c.entry_id) >= 0) begin
          step_out.push_back(make_result(ST_DUP, '0, 0, 1'b1));
        end else if (live_count >= QUEUE_DEPTH) begin
          step_out.push_back(make_result(ST_FULL, '0, 0, 1'b1));
        end else begin
          queue_slot[live_count] = '{id: c.entry_id, timed: c.timed,
                                     limit: c.wait_limit, elapsed: '0};
          live_count++;
          step_out.push_back(make_result(ST_OK, '0, 0, 1'b1));
        end
      end
      MODE_REMOVE, MODE_FIND: begin
        pos = locate_id(c.entry_id);
        if (pos < 0) begin
          step_out.push_back(make_result(ST_NOTFOUND, '0, 0, 1'b1));
        end else begin
          if (c.mode == MODE_REMOVE) drop_slot(pos);
          step_out.push_back(make_result(ST_OK, c.entry_id, 0, 1'b1));
        end
      end
      MODE_TAKE_FIRST, MODE_TAKE_UNTIMED, MODE_TAKE_TIMED: begin
        for (i = 0; i < live_count && pos < 0; i++)
          if (c.mode == MODE_TAKE_FIRST || queue_slot[i].timed == (c.mode == MODE_TAKE_TIMED))
            pos = i;
        if (pos < 0) begin
          step_out.push_back(make_result(ST_NOTFOUND, '0, 0, 1'b1));
        end else begin
          step_out.push_back(make_result(ST_OK, queue_slot[pos].id, 0, 1'b1));
          drop_slot(pos);
        end
      end
      MODE_TICK: begin
        i = 0;
        while (i < live_count) begin
          if (queue_slot[i].timed) begin
            if (queue_slot[i].elapsed != '1) queue_slot[i].elapsed++;
            if (queue_slot[i].elapsed >= queue_slot[i].limit) begin
              step_out.push_back(make_result(ST_OK, queue_slot[i].id, 0, 1'b0));
              released++;
              drop_slot(i);
              continue;
            end
          end
          i++;
        end
        step_out.push_back(make_result(ST_OK, '0, released, 1'b1));
      end
      default: begin
        step_out.push_back(make_result(ST_OK, '0, 0, 1'b1));
      end
    endcase
    foreach (step_out[k]) begin
      step_out[k].occ = COUNT_W'(live_count);
      pending_results.push_back(step_out[k]);
    end
  endfunction

  function automatic void queue_cmd(input logic [MODE_W-1:0] mode,
                                    input logic [ID_W-1:0] entry_id, input logic timed,
                                    input logic [LIMIT_W-1:0] wait_limit);
    command_t c;
    c.mode       = mode;
    c.entry_id   = entry_id;
    c.timed      = timed;
    c.wait_limit = wait_limit;
    cmd_backlog.push_back(c);
  endfunction

  function automatic void queue_random_cmd(input int phase);
    int                 roll;
    logic [MODE_W-1:0]  mode;
    logic [ID_W-1:0]    entry_id;
    logic [LIMIT_W-1:0] wait_limit;
    roll = $urandom_range(0, 99);
    mode = MODE_UNUSED;
    for (int k = 6; k >= 0; k--)
      if (roll < MODE_CUT[phase][k]) mode = MODE_ORDER[k];
    entry_id   = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, ID_POOL_SIZE - 1)]
                                              : ID_W'($urandom);
    wait_limit = ($urandom_range(0, 9) < 7) ? LIMIT_W'($urandom_range(0, 5))
                                            : LIMIT_W'($urandom);
    queue_cmd(mode, entry_id, 1'($urandom_range(0, 1)), wait_limit);
  endfunction

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || in_if.valid || pending_results.size() != 0)
      @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else begin
      if (in_if.valid && in_if.ready) apply_command(on_wire);
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0 || cmd_backlog.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_if.valid <= 1'b0;
        end else begin
          on_wire = cmd_backlog.pop_front();
          in_if.valid      <= 1'b1;
          in_if.mode       <= on_wire.mode;
          in_if.entry_id   <= on_wire.entry_id;
          in_if.timed      <= on_wire.timed;
          in_if.wait_limit <= on_wire.wait_limit;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 40)
                                                     : $urandom_range(0, 7);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      style_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = '{status: out_if.status, id: out_if.result_id, rel: out_if.released_count,
                occ: out_if.occupancy, last: out_if.last};
        if (pending_results.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("%0t: unexpected result: status %0d id %h rel %0d occ %0d last %0d",
                     $time, got.status, got.id, got.rel, got.occ, got.last);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.id !== want.id || got.rel !== want.rel ||
              got.occ !== want.occ || got.last !== want.last) begin
            fault_count++;
            if (fault_count <= 10) begin
              $write("%0t: mismatch: expected status %0d id %h rel %0d occ %0d last %0d,",
                     $time, want.status, want.id, want.rel, want.occ, want.last);
              $display(" got status %0d id %h rel %0d occ %0d last %0d",
                       got.status, got.id, got.rel, got.occ, got.last);
            end
          end
        end
      end
      if (style_left == 0) begin
        style_left  = $urandom_range(16, 96);
        ready_style = $urandom_range(0, 3);
        stall_word  = 8'($urandom) | 8'h01;
      end
      style_left--;
      case (ready_style)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= 1'($urandom_range(0, 1));
        2: begin
          out_if.ready <= stall_word[0];
          stall_word = {stall_word[0], stall_word[7:1]};
        end
        default: out_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int  k;
    int  n;
    int  span;
    int  phase;
    bit  paused_mid;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.mode       = '0;
    in_if.entry_id   = '0;
    in_if.timed      = 1'b0;
    in_if.wait_limit = '0;
    out_if.ready     = 1'b0;
    paused_mid       = 1'b0;
    foreach (id_pool[j]) id_pool[j] = ID_W'($urandom);

    queue_cmd(MODE_TICK, '0, 1'b0, '0);
    queue_cmd(MODE_TAKE_FIRST, '0, 1'b0, '0);
    queue_cmd(MODE_TAKE_TIMED, '0, 1'b0, '0);
    queue_cmd(MODE_FIND, '0, 1'b0, '0);
    queue_cmd(MODE_UNUSED, '1, 1'b1, '1);
    for (k = 0; k < QUEUE_DEPTH; k++)
      queue_cmd(MODE_INSERT, ID_W'(k * 16'h1111), k[0],
                k[0] ? LIMIT_W'(k / 4) : ~LIMIT_W'(k));
    queue_cmd(MODE_INSERT, 16'h2222, 1'b1, 16'h0001);
    queue_cmd(MODE_INSERT, 16'hABCD, 1'b0, 16'h0001);
    queue_cmd(MODE_TICK, '0, 1'b0, '0);
    queue_cmd(MODE_TAKE_UNTIMED, '0, 1'b0, '0);
    queue_cmd(MODE_REMOVE, 16'h8888, 1'b0, '0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    wait_drained();
    n = 0;
    while (n < RANDOM_ITEMS) begin
      phase = $urandom_range(0, 2);
      span  = $urandom_range(8, 20);
      for (k = 0; k < span && n < RANDOM_ITEMS; k++) begin
        queue_random_cmd(phase);
        n++;
      end
      if (!paused_mid && n >= RANDOM_ITEMS / 2) begin
        wait_drained();
        paused_mid = 1'b1;
      end
    end
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
